### design/pci_pkg.sv
// Package for the palette colour interpolator: field widths, reset values,
// command and register index codes, and parameter defaults.
// No dependencies; compiled first.
`default_nettype none

package pci_pkg;

   // field widths
   localparam int VALUE_W    = 16;
   localparam int CHAN_W     = 8;
   localparam int ENTRY_W    = 4 * CHAN_W;
   localparam int INDEX_W    = 8;
   localparam int SIZE_W     = 9;
   localparam int REPEAT_W   = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;

   // parameter defaults and limits
   localparam int MAX_ENTRIES_DEF   = 256;
   localparam int FRACTION_BITS_DEF = 16;
   localparam int FRACTION_BITS_MAX = 24;

   // register reset values
   localparam logic [SIZE_W-1:0]   SIZE_RESET   = 9'd2;
   localparam logic [REPEAT_W-1:0] REPEAT_RESET = 6'd1;

   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_MAP   = 1'b1
   } command_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PALETTE_SIZE = 2'd0,
      CSR_REPEAT_TIMES = 2'd1
   } csr_index_type;

endpackage

`default_nettype wire

### design/pci_if.sv
// Channel interfaces of the palette colour interpolator: request, response
// and register write channels, each with valid/ready and its payload.
// Depends on pci_pkg for the field widths.
`default_nettype none

interface pci_req_if;
   logic                             valid;
   logic                             ready;
   logic                             command;
   logic [pci_pkg::INDEX_W-1:0]      entry_index;
   logic [pci_pkg::CHAN_W-1:0]       entry_red;
   logic [pci_pkg::CHAN_W-1:0]       entry_green;
   logic [pci_pkg::CHAN_W-1:0]       entry_blue;
   logic [pci_pkg::CHAN_W-1:0]       entry_alpha;
   logic [pci_pkg::VALUE_W-1:0]      value;

   modport source (
      output valid, command, entry_index, entry_red, entry_green, entry_blue,
             entry_alpha, value,
      input  ready
   );
   modport sink (
      input  valid, command, entry_index, entry_red, entry_green, entry_blue,
             entry_alpha, value,
      output ready
   );
endinterface

interface pci_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [pci_pkg::CHAN_W-1:0] red;
   logic [pci_pkg::CHAN_W-1:0] green;
   logic [pci_pkg::CHAN_W-1:0] blue;
   logic [pci_pkg::CHAN_W-1:0] alpha;

   modport source (output valid, red, green, blue, alpha, input ready);
   modport sink (input valid, red, green, blue, alpha, output ready);
endinterface

interface pci_csr_if;
   logic                           valid;
   logic                           ready;
   logic [pci_pkg::CSR_IDX_W-1:0]  index;
   logic [pci_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### design/palette_color_interpolator.sv
// Palette colour interpolator top level: palette memory, value scaling
// pipeline and per-channel blend. Depends on pci_pkg and pci_if.
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+-----------------------------------------
//   req_ch   | in  | valid/ready   | command, entry_index, entry_rgba, value
//   rsp_ch   | out | valid/ready   | red, green, blue, alpha
//   csr_ch   | in  | valid/ready=1 | index, data
//
// One word per cycle in and out while rsp_ch.ready is high; a map word's
// colour passes every stage and the output register. The palette memory,
// serving one write or one pair of neighbouring reads per cycle, sets the rate.
// Every stage holds its word while the next one is full, so bubbles close
// up and req_ch.ready drops only when all stages and the output hold words.
// Reset clears the registers and the pipeline; the palette itself has no
// clearing pass and holds unknown data until entries are written.
`default_nettype none

module palette_color_interpolator #(
   parameter int MAX_ENTRIES   = pci_pkg::MAX_ENTRIES_DEF,
   parameter int FRACTION_BITS = pci_pkg::FRACTION_BITS_DEF
) (
   input  wire       clock,
   input  wire       reset,
   pci_req_if.sink   req_ch,
   pci_rsp_if.source rsp_ch,
   pci_csr_if.sink   csr_ch
);

   localparam int AW   = $clog2(MAX_ENTRIES);
   localparam int VW   = pci_pkg::VALUE_W;
   localparam int RW   = pci_pkg::REPEAT_W;
   localparam int CW   = pci_pkg::CHAN_W;
   localparam int EW   = pci_pkg::ENTRY_W;
   localparam int XW   = pci_pkg::INDEX_W;
   localparam int QW   = VW + RW;
   localparam int PW   = QW + AW;
   localparam int IW   = RW + AW;
   localparam int WT   = FRACTION_BITS + 1;
   localparam int FMAX = pci_pkg::FRACTION_BITS_MAX;

   localparam logic [WT-1:0]   WEIGHT_ONE  = {1'b1, {FRACTION_BITS{1'b0}}};
   localparam logic [WT+CW:0]  WEIGHT_HALF =
      {{(CW+2){1'b0}}, 1'b1, {(FRACTION_BITS-1){1'b0}}};

   // ---------------------------------------------------------------------
   // Registers and derived configuration
   // ---------------------------------------------------------------------
   logic [pci_pkg::SIZE_W-1:0] size_cfg_ff;
   logic [RW-1:0]              repeat_cfg_ff;
   logic [AW-1:0]              segs_ff;
   logic [AW-1:0]              segs_in;
   logic [AW-1:0]              mir_base_ff;
   logic [AW-1:0]              mir_base_in;
   logic [31:0]                size_w;
   logic [RW-1:0]              rep_mag;
   logic                       rep_pos;
   logic                       rep_neg;

   // clamp palette size to [2, MAX_ENTRIES]
   always_comb begin
      priority if (32'(size_cfg_ff) < 32'd2) begin
         size_w = 32'd2;
      end else if (32'(size_cfg_ff) > 32'(MAX_ENTRIES)) begin
         size_w = 32'(MAX_ENTRIES);
      end else begin
         size_w = 32'(size_cfg_ff);
      end
   end

   assign segs_in     = AW'(size_w - 32'd1);
   assign mir_base_in = AW'(size_w - 32'd2);

   // magnitude and sign of the repeat count
   assign rep_neg = repeat_cfg_ff[RW-1];
   assign rep_pos = !repeat_cfg_ff[RW-1] && (repeat_cfg_ff != '0);
   assign rep_mag = rep_neg ? (~repeat_cfg_ff + RW'(1)) : repeat_cfg_ff;

   assign csr_ch.ready = 1'b1;

   // take register writes, follow them with the derived segment counts
   always_ff @(posedge clock) begin
      if (reset) begin
         size_cfg_ff   <= pci_pkg::SIZE_RESET;
         repeat_cfg_ff <= pci_pkg::REPEAT_RESET;
         segs_ff       <= AW'(1);
         mir_base_ff   <= '0;
      end else begin
         segs_ff     <= segs_in;
         mir_base_ff <= mir_base_in;
         if (csr_ch.valid) begin
            unique case (csr_ch.index)
               pci_pkg::CSR_PALETTE_SIZE: size_cfg_ff   <= csr_ch.data;
               pci_pkg::CSR_REPEAT_TIMES: repeat_cfg_ff <= csr_ch.data[RW-1:0];
               default: ;
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stage control: each stage loads when it is empty or its word moves on
   // ---------------------------------------------------------------------
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, rsp_valid_ff;
   logic ld1, ld2, ld3, ld4, ld5, ld_out;

   assign ld_out = !rsp_valid_ff || rsp_ch.ready;
   assign ld5    = !v5_ff || ld_out;
   assign ld4    = !v4_ff || ld5;
   assign ld3    = !v3_ff || ld4;
   assign ld2    = !v2_ff || ld3;
   assign ld1    = !v1_ff || ld2;

   assign req_ch.ready = ld1;

   // ---------------------------------------------------------------------
   // Stage payloads
   // ---------------------------------------------------------------------
   pci_pkg::command_type cmd1_ff, cmd2_ff, cmd3_ff, cmd4_ff;
   logic [XW-1:0]        widx1_ff, widx2_ff, widx3_ff, widx4_ff;
   logic [EW-1:0]        wdata1_ff, wdata2_ff, wdata3_ff, wdata4_ff;
   logic [VW-1:0]        val1_ff;
   logic [QW-1:0]        q2_ff;
   logic [QW-1:0]        q_in;
   logic [PW-1:0]        p3_ff;
   logic [PW-1:0]        p_in;
   logic [IW-1:0]        ps3_ff;
   logic [IW-1:0]        ps_in;
   logic                 par3_ff;
   logic [AW-1:0]        idx4_ff;
   logic [AW-1:0]        idx_in;
   logic [WT-1:0]        t4_ff, t5_ff;
   logic [WT-1:0]        t_in;
   logic [EW-1:0]        rd_lo_ff, rd_hi_ff;
   logic [CW-1:0]        red_ff, green_ff, blue_ff, alpha_ff;

   // scale: value * |repeat|, then by the segment count
   assign q_in  = QW'(val1_ff) * QW'(rep_mag);
   assign p_in  = PW'(q2_ff) * PW'(segs_ff);
   assign ps_in = IW'(q2_ff[QW-1:VW]) * IW'(segs_ff);

   // segment, direction and weight
   logic [IW-1:0]      seg_i;
   logic [IW-1:0]      rem_full;
   logic [AW-1:0]      rem;
   logic               fwd;
   logic [VW+FMAX-1:0] frac_wide;
   logic [FRACTION_BITS-1:0] t_frac;

   assign seg_i     = p3_ff[PW-1:VW];
   assign rem_full  = seg_i - ps3_ff;
   assign rem       = rem_full[AW-1:0];
   assign fwd       = (!par3_ff && rep_pos) || (par3_ff && rep_neg);
   assign frac_wide = {p3_ff[VW-1:0], {FMAX{1'b0}}};
   assign t_frac    = frac_wide[VW+FMAX-1 -: FRACTION_BITS];
   assign t_in      = fwd ? {1'b0, t_frac} : (WEIGHT_ONE - {1'b0, t_frac});
   assign idx_in    = fwd ? rem : (mir_base_ff - rem);

   // valid chain; write words end at the memory stage
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ld1)    v1_ff        <= req_ch.valid;
         if (ld2)    v2_ff        <= v1_ff;
         if (ld3)    v3_ff        <= v2_ff;
         if (ld4)    v4_ff        <= v3_ff;
         if (ld5)    v5_ff        <= v4_ff && (cmd4_ff == pci_pkg::CMD_MAP);
         if (ld_out) rsp_valid_ff <= v5_ff;
      end
   end

   // advance payloads
   always_ff @(posedge clock) begin
      if (ld1) begin
         cmd1_ff   <= pci_pkg::command_type'(req_ch.command);
         widx1_ff  <= req_ch.entry_index;
         wdata1_ff <= {req_ch.entry_red, req_ch.entry_green,
                       req_ch.entry_blue, req_ch.entry_alpha};
         val1_ff   <= req_ch.value;
      end
      if (ld2) begin
         cmd2_ff   <= cmd1_ff;
         widx2_ff  <= widx1_ff;
         wdata2_ff <= wdata1_ff;
         q2_ff     <= q_in;
      end
      if (ld3) begin
         cmd3_ff   <= cmd2_ff;
         widx3_ff  <= widx2_ff;
         wdata3_ff <= wdata2_ff;
         p3_ff     <= p_in;
         ps3_ff    <= ps_in;
         par3_ff   <= q2_ff[VW];
      end
      if (ld4) begin
         cmd4_ff   <= cmd3_ff;
         widx4_ff  <= widx3_ff;
         wdata4_ff <= wdata3_ff;
         idx4_ff   <= idx_in;
         t4_ff     <= t_in;
      end
      if (ld5) begin
         t5_ff <= t4_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Palette memory: one write or two reads as a word enters stage five
   // ---------------------------------------------------------------------
   logic [EW-1:0] palette_mem_ff [MAX_ENTRIES];
   logic [31:0]   waddr_w;
   logic [AW-1:0] waddr;
   logic          wr_en;
   logic [AW-1:0] idx_hi;

   assign waddr_w = 32'(widx4_ff);
   assign waddr   = waddr_w[AW-1:0];
   assign wr_en   = ld5 && v4_ff && (cmd4_ff == pci_pkg::CMD_WRITE) &&
                    (waddr_w < 32'(MAX_ENTRIES));
   assign idx_hi  = idx4_ff + AW'(1);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         palette_mem_ff[waddr] <= wdata4_ff;
      end
      if (ld5) begin
         rd_lo_ff <= palette_mem_ff[idx4_ff];
         rd_hi_ff <= palette_mem_ff[idx_hi];
      end
   end

   // ---------------------------------------------------------------------
   // Blend two entries per channel, round half up, saturate
   // ---------------------------------------------------------------------
   function automatic logic [CW-1:0] blend(input logic [CW-1:0] c_lo,
                                           input logic [CW-1:0] c_hi,
                                           input logic [WT-1:0] wt);
      logic [WT+CW-1:0] p_lo;
      logic [WT+CW-1:0] p_hi;
      logic [WT+CW:0]   acc;
      logic [CW+1:0]    rounded;
      p_lo    = (WT+CW)'(WEIGHT_ONE - wt) * (WT+CW)'(c_lo);
      p_hi    = (WT+CW)'(wt) * (WT+CW)'(c_hi);
      acc     = {1'b0, p_lo} + {1'b0, p_hi} + WEIGHT_HALF;
      rounded = acc[WT+CW:FRACTION_BITS];
      return (rounded[CW+1:CW] != 2'b00) ? {CW{1'b1}} : rounded[CW-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (ld_out) begin
         red_ff   <= blend(rd_lo_ff[3*CW +: CW], rd_hi_ff[3*CW +: CW], t5_ff);
         green_ff <= blend(rd_lo_ff[2*CW +: CW], rd_hi_ff[2*CW +: CW], t5_ff);
         blue_ff  <= blend(rd_lo_ff[CW +: CW], rd_hi_ff[CW +: CW], t5_ff);
         alpha_ff <= blend(rd_lo_ff[0 +: CW], rd_hi_ff[0 +: CW], t5_ff);
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.red   = red_ff;
   assign rsp_ch.green = green_ff;
   assign rsp_ch.blue  = blue_ff;
   assign rsp_ch.alpha = alpha_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // a palette write never turns into a result
   a_write_no_result: assert property (@(posedge clock) disable iff (reset)
      (ld5 && v4_ff && (cmd4_ff == pci_pkg::CMD_WRITE)) |=> !v5_ff)
      else $error("palette write word reached the blend stage");

   // segment remainder never goes negative
   a_rem_non_negative: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && (cmd3_ff == pci_pkg::CMD_MAP)) |-> (seg_i >= ps3_ff))
      else $error("segment remainder underflow");

   // input stalls only when every stage holds a word
   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (v1_ff && v2_ff && v3_ff && v4_ff && v5_ff &&
                         rsp_valid_ff && !rsp_ch.ready))
      else $error("input stalled with a free stage");

   // read data holds while the blend stage waits
   a_read_hold: assert property (@(posedge clock) disable iff (reset)
      (v5_ff && !ld5) |=> ($stable(rd_lo_ff) && $stable(rd_hi_ff)))
      else $error("palette read data changed under a held word");

endmodule

`default_nettype wire

### verif/palette_map_checker.sv
// Checker for the palette colour interpolator: watches the request, response
// and register channels, predicts each colour word and compares it.
// Depends on pci_pkg and the channel interfaces in pci_if.
module palette_map_checker (
   input  wire  clock,
   input  wire  reset,
   pci_req_if   req_ch,
   pci_rsp_if   rsp_ch,
   pci_csr_if   csr_ch,
   output int   failures,
   output int   pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC = pci_pkg::FRACTION_BITS_DEF;
   localparam int VW = pci_pkg::VALUE_W;
   localparam int CW = pci_pkg::CHAN_W;
   localparam longint unsigned WEIGHT_ONE = 64'd1 << FRAC;
   localparam longint unsigned WEIGHT_HALF = 64'd1 << (FRAC - 1);
   localparam int WIDEN = FRAC >= VW ? FRAC - VW : 0;
   localparam int NARROW = FRAC < VW ? VW - FRAC : 0;

   typedef struct packed {
      logic [CW-1:0] red;
      logic [CW-1:0] green;
      logic [CW-1:0] blue;
      logic [CW-1:0] alpha;
   } colour_type;

   logic [pci_pkg::ENTRY_W-1:0]         palette [pci_pkg::MAX_ENTRIES_DEF];
   logic [pci_pkg::SIZE_W-1:0]          size_reg;
   logic signed [pci_pkg::REPEAT_W-1:0] repeat_reg;
   colour_type                          colours_due [$];
   colour_type                          seen;
   colour_type                          want;

   // weighted sum of two channel values, rounded to nearest with halves up
   function automatic logic [CW-1:0] mix(longint unsigned lo, longint unsigned hi,
                                         longint unsigned w);
      longint unsigned sum;
      sum = ((WEIGHT_ONE - w) * lo + w * hi + WEIGHT_HALF) >> FRAC;
      return sum > 255 ? 8'hFF : sum[CW-1:0];
   endfunction

   // scale the value over the repeated palette, pick the segment and blend
   function automatic colour_type interpolate_colour(logic [VW-1:0] v);
      longint unsigned sz, segs, reps, scaled, seg, w, pass_no, idx;
      int              r;
      bit              fwd;
      logic [pci_pkg::ENTRY_W-1:0] lo_e, hi_e;
      colour_type      c;
      sz = size_reg;
      if (sz < 2) sz = 2;
      if (sz > pci_pkg::MAX_ENTRIES_DEF) sz = pci_pkg::MAX_ENTRIES_DEF;
      segs = sz - 1;
      r = repeat_reg;
      reps = r < 0 ? -r : r;
      scaled = v;
      scaled = scaled * segs * reps;
      seg = scaled >> VW;
      w = ((scaled & 64'hFFFF) << WIDEN) >> NARROW;
      pass_no = seg / segs;
      fwd = (pass_no[0] == 1'b0 && r > 0) || (pass_no[0] == 1'b1 && r < 0);
      if (fwd) begin
         idx = seg % segs;
      end else begin
         idx = (sz - 2) - (seg % segs);
         w = WEIGHT_ONE - w;
      end
      lo_e = palette[idx];
      hi_e = palette[idx + 1];
      c.red   = mix(lo_e[31:24], hi_e[31:24], w);
      c.green = mix(lo_e[23:16], hi_e[23:16], w);
      c.blue  = mix(lo_e[15:8],  hi_e[15:8],  w);
      c.alpha = mix(lo_e[7:0],   hi_e[7:0],   w);
      return c;
   endfunction

   task automatic check_channel(string name, logic [CW-1:0] exp_val,
                                logic [CW-1:0] got);
      if (got !== exp_val) begin
         $error("%s: expected %0d, got %0d", name, exp_val, got);
         failures++;
      end
   endtask

   // track registers and palette, queue predictions, retire colour words
   always @(posedge clock) begin
      if (reset) begin
         size_reg = pci_pkg::SIZE_RESET;
         repeat_reg = pci_pkg::REPEAT_RESET;
         colours_due.delete();
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            if (csr_ch.index == pci_pkg::CSR_PALETTE_SIZE)
               size_reg = csr_ch.data;
            else if (csr_ch.index == pci_pkg::CSR_REPEAT_TIMES)
               repeat_reg = csr_ch.data[pci_pkg::REPEAT_W-1:0];
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen = {rsp_ch.red, rsp_ch.green, rsp_ch.blue, rsp_ch.alpha};
            if (colours_due.size() == 0) begin
               $error("colour word %h arrived with none expected", seen);
               failures++;
            end else begin
               want = colours_due.pop_front();
               check_channel("red",   want.red,   seen.red);
               check_channel("green", want.green, seen.green);
               check_channel("blue",  want.blue,  seen.blue);
               check_channel("alpha", want.alpha, seen.alpha);
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            if (req_ch.command == pci_pkg::CMD_WRITE)
               palette[req_ch.entry_index] = {req_ch.entry_red, req_ch.entry_green,
                                              req_ch.entry_blue, req_ch.entry_alpha};
            else
               colours_due.push_back(interpolate_colour(req_ch.value));
         end
      end
      pending = colours_due.size();
   end

endmodule

### verif/tb_palette_color_interpolator.sv
// Top of the palette colour interpolator testbench: clock, reset, stimulus,
// register settings, response stalls and the verdict.
// Depends on pci_pkg, pci_if, palette_map_checker and the block itself.
module tb_palette_color_interpolator;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT  = 2000;
   localparam int HOLD_CYCLES = 300;
   localparam int MAX_WAIT    = 18;
   localparam int SETTLE      = 16;
   localparam int PHASES      = 10;
   localparam int PHASE_WORDS = 145;
   localparam int XW          = pci_pkg::INDEX_W;
   localparam int EW          = pci_pkg::ENTRY_W;
   localparam int VW          = pci_pkg::VALUE_W;

   logic clock;
   logic reset;
   int   failures;
   int   pending;
   int   idle_cycles = 0;
   int   sent_words = 0;
   bit   sender_burst = 0;
   bit   hold_request = 0;

   pci_req_if req_ch ();
   pci_rsp_if rsp_ch ();
   pci_csr_if csr_ch ();

   palette_color_interpolator dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   palette_map_checker colour_check (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .rsp_ch   (rsp_ch),
      .csr_ch   (csr_ch),
      .failures (failures),
      .pending  (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // offer one word after a random gap and hold it until accepted
   task automatic send_word(pci_pkg::command_type cmd, logic [XW-1:0] idx,
                            logic [EW-1:0] rgba, logic [VW-1:0] v);
      int gap;
      if (sent_words % 32 == 0) sender_burst = ($urandom_range(0, 3) == 0);
      sent_words++;
      gap = sender_burst ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.command     <= cmd;
      req_ch.entry_index <= idx;
      req_ch.entry_red   <= rgba[31:24];
      req_ch.entry_green <= rgba[23:16];
      req_ch.entry_blue  <= rgba[15:8];
      req_ch.entry_alpha <= rgba[7:0];
      req_ch.value       <= v;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   task automatic store_entry(logic [XW-1:0] idx, logic [EW-1:0] rgba);
      send_word(pci_pkg::CMD_WRITE, idx, rgba, VW'($urandom));
   endtask

   task automatic map_value(logic [VW-1:0] v);
      send_word(pci_pkg::CMD_MAP, XW'($urandom), $urandom, v);
   endtask

   // drop valid, drain every colour word, then let trailing writes finish
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_setting(int size, int rep);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= pci_pkg::CSR_PALETTE_SIZE;
      csr_ch.data  <= size[pci_pkg::SIZE_W-1:0];
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.index <= pci_pkg::CSR_REPEAT_TIMES;
      csr_ch.data  <= pci_pkg::CSR_DATA_W'(rep[pci_pkg::REPEAT_W-1:0]);
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // response side: random stalls, bursts without stalls, one long hold-off
   initial begin
      int stall;
      int taken;
      bit burst;
      taken = 0;
      burst = 0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         if (taken % 32 == 0) burst = ($urandom_range(0, 3) == 0);
         taken++;
         if (hold_request) begin
            stall = HOLD_CYCLES;
            hold_request = 0;
         end else begin
            stall = burst ? 0 : $urandom_range(0, MAX_WAIT);
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         @(negedge clock);
      end
   end

   // end the run when no word has moved for too long
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("[palette_color_interpolator] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int size;
      int rep;
      int roll;
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.command     = pci_pkg::CMD_WRITE;
      req_ch.entry_index = '0;
      req_ch.entry_red   = '0;
      req_ch.entry_green = '0;
      req_ch.entry_blue  = '0;
      req_ch.entry_alpha = '0;
      req_ch.value       = '0;
      rsp_ch.ready       = 1'b0;
      csr_ch.valid       = 1'b0;
      csr_ch.index       = pci_pkg::CSR_PALETTE_SIZE;
      csr_ch.data        = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // fill the whole palette so no map ever reads an unwritten entry
      for (int e = 0; e < pci_pkg::MAX_ENTRIES_DEF; e++) store_entry(XW'(e), $urandom);

      // largest palette, single pass: field extremes and end entries
      settle();
      write_setting(256, 1);
      store_entry(8'd0, 32'h0000_0000);
      store_entry(8'd255, 32'hFFFF_FFFF);
      store_entry(8'd1, 32'hFF00_FF00);
      store_entry(8'd254, 32'h00FF_00FF);
      map_value(16'h0000);
      map_value(16'hFFFF);
      map_value(16'h8000);
      map_value(16'h0001);
      // two passes: exact segment boundary, second pass mirrored
      settle();
      write_setting(2, 2);
      map_value(16'h8000);
      map_value(16'h0000);
      map_value(16'hFFFF);
      map_value(16'h4000);
      // size below range with zero repeat gives the last entry
      settle();
      write_setting(0, 0);
      map_value(16'h1234);
      map_value(16'hFFFF);
      // size above range, repeat at its most negative value
      settle();
      write_setting(511, -32);
      map_value(16'hFFFF);
      map_value(16'h8001);
      // negative repeat: first pass mirrored
      settle();
      write_setting(17, -3);
      map_value(16'h0000);
      map_value(16'h5555);
      map_value(16'hAAAA);

      // random words under a series of settings, extremes first
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin size = 2;   rep = 16;  end
            1: begin size = 256; rep = -16; end
            2: begin size = 256; rep = 16;  end
            3: begin size = 1;   rep = 31;  end
            4: begin size = 300; rep = -1;  end
            9: begin
               size = $urandom_range(0, 511);
               rep  = int'($urandom_range(0, 63)) - 32;
            end
            default: begin
               size = $urandom_range(2, 256);
               rep  = int'($urandom_range(0, 32)) - 16;
            end
         endcase
         settle();
         write_setting(size, rep);
         if (ph == 2) hold_request = 1;
         for (int n = 0; n < PHASE_WORDS; n++) begin
            roll = $urandom_range(0, 9);
            if (roll < 2)
               store_entry(XW'($urandom), $urandom);
            else if (roll == 2)
               map_value(16'h0000);
            else if (roll == 3)
               map_value(16'hFFFF);
            else
               map_value(VW'($urandom));
         end
      end

      settle();
      if (failures == 0)
         $display("[palette_color_interpolator] OK");
      else
         $display("[palette_color_interpolator] ERROR");
      $finish;
   end

endmodule
